FILE: design/slm_pkg.sv
// slm_pkg: shared constants, element type and inter-module structs for the
// sorted list merger. No dependencies.
package slm_pkg;

    localparam int LIST_DEPTH   = 32;
    localparam int KEY_BITS     = 32;
    localparam int PAYLOAD_BITS = 32;

    localparam int ADDR_BITS    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_BITS     = $clog2(LIST_DEPTH + 1);
    localparam int OUT_CNT_BITS = $clog2(2 * LIST_DEPTH + 1);
    localparam int ENTRY_BITS   = KEY_BITS + PAYLOAD_BITS;

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_PICK  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    typedef logic [KEY_BITS-1:0]     key_t;
    typedef logic [PAYLOAD_BITS-1:0] payload_t;
    typedef logic [ADDR_BITS-1:0]    addr_t;
    typedef logic [CNT_BITS-1:0]     cnt_t;

    typedef struct packed {
        key_t     key;
        payload_t payload;
    } entry_t;

    typedef struct packed {
        logic   we_first;
        logic   we_second;
        addr_t  addr_first;
        addr_t  addr_second;
        entry_t data;
    } store_wr_t;

    typedef struct packed {
        logic   valid;
        entry_t elem;
        logic   to_second;
        logic   equals_next;
        logic   last;
    } emit_req_t;

    typedef struct packed {
        logic busy;
        cnt_t first_count;
        cnt_t second_count;
    } seq_status_t;

endpackage

FILE: design/slm_list_ram.sv
// slm_list_ram: generic single-write, single-read RAM with registered read data.
// Holds one sorted list. No dependencies.
module slm_list_ram #(
    parameter int DEPTH     = 32,
    parameter int WIDTH     = 64,
    parameter int ADDR_BITS = 5
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: design/slm_merge_seq.sv
// slm_merge_seq: load counters and merge sequencer around one shared key less-than comparator.
// Holds one pending result to resolve equals_next. Depends on slm_pkg.
module slm_merge_seq import slm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        elem_valid,
    input  key_t        elem_key,
    input  payload_t    elem_payload,
    input  logic        from_second,
    input  logic        load_done,
    input  entry_t      rd_first,
    input  entry_t      rd_second,
    input  logic        emit_ready,
    output store_wr_t   wr,
    output addr_t       raddr_first,
    output addr_t       raddr_second,
    output emit_req_t   emit,
    output seq_status_t status
);

    logic [1:0]              state_reg, state_next;
    cnt_t                    cnt1_reg, cnt1_next;
    cnt_t                    cnt2_reg, cnt2_next;
    cnt_t                    idx1_reg, idx1_next;
    cnt_t                    idx2_reg, idx2_next;
    logic [OUT_CNT_BITS-1:0] outn_reg, outn_next;
    logic                    pend_vld_reg, pend_vld_next;
    entry_t                  pend_reg, pend_next;
    logic                    pend_sec_reg, pend_sec_next;

    logic                    accept;
    logic                    avail1, avail2, take1;
    entry_t                  pick;
    logic                    pick_sec;
    logic [OUT_CNT_BITS-1:0] total;
    cnt_t                    load_cnt1, load_cnt2;

    assign accept = elem_valid && (state_reg == S_LOAD);

    assign wr.data        = '{key: elem_key, payload: elem_payload};
    assign wr.addr_first  = cnt1_reg[ADDR_BITS-1:0];
    assign wr.addr_second = cnt2_reg[ADDR_BITS-1:0];
    assign wr.we_first    = accept && !from_second && (cnt1_reg != CNT_BITS'(LIST_DEPTH));
    assign wr.we_second   = accept && from_second && (cnt2_reg != CNT_BITS'(LIST_DEPTH));

    assign load_cnt1 = cnt1_reg + CNT_BITS'(wr.we_first);
    assign load_cnt2 = cnt2_reg + CNT_BITS'(wr.we_second);

    assign raddr_first  = idx1_reg[ADDR_BITS-1:0];
    assign raddr_second = idx2_reg[ADDR_BITS-1:0];

    assign avail1   = idx1_reg < cnt1_reg;
    assign avail2   = idx2_reg < cnt2_reg;
    assign take1    = avail1 && (!avail2 || (rd_first.key < rd_second.key));
    assign pick     = take1 ? rd_first : rd_second;
    assign pick_sec = outn_reg >= OUT_CNT_BITS'(cnt1_reg);
    assign total    = OUT_CNT_BITS'(cnt1_reg) + OUT_CNT_BITS'(cnt2_reg);

    assign status.busy         = (state_reg != S_LOAD);
    assign status.first_count  = cnt1_reg;
    assign status.second_count = cnt2_reg;

    always_comb
    begin
        state_next    = state_reg;
        cnt1_next     = cnt1_reg;
        cnt2_next     = cnt2_reg;
        idx1_next     = idx1_reg;
        idx2_next     = idx2_reg;
        outn_next     = outn_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        pend_sec_next = pend_sec_reg;
        emit          = '0;
        emit.elem     = pend_reg;
        emit.to_second = pend_sec_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    cnt1_next = load_cnt1;
                    cnt2_next = load_cnt2;
                    if (load_done && ((load_cnt1 != '0) || (load_cnt2 != '0)))
                    begin
                        state_next    = S_READ;
                        idx1_next     = '0;
                        idx2_next     = '0;
                        outn_next     = '0;
                        pend_vld_next = 1'b0;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_PICK;
            end
            S_PICK:
            begin
                if (!pend_vld_reg || emit_ready)
                begin
                    emit.valid       = pend_vld_reg;
                    emit.equals_next = (pend_reg.key == pick.key);
                    pend_next        = pick;
                    pend_sec_next    = pick_sec;
                    pend_vld_next    = 1'b1;
                    outn_next        = outn_reg + 1'b1;
                    if (take1)
                    begin
                        idx1_next = idx1_reg + 1'b1;
                    end
                    else
                    begin
                        idx2_next = idx2_reg + 1'b1;
                    end
                    if ((outn_reg + 1'b1) == total)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_FLUSH:
            begin
                emit.valid = 1'b1;
                emit.last  = 1'b1;
                if (emit_ready)
                begin
                    state_next    = S_LOAD;
                    cnt1_next     = '0;
                    cnt2_next     = '0;
                    pend_vld_next = 1'b0;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            cnt1_reg     <= '0;
            cnt2_reg     <= '0;
            idx1_reg     <= '0;
            idx2_reg     <= '0;
            outn_reg     <= '0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt1_reg     <= cnt1_next;
            cnt2_reg     <= cnt2_next;
            idx1_reg     <= idx1_next;
            idx2_reg     <= idx2_next;
            outn_reg     <= outn_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        pend_sec_reg <= pend_sec_next;
    end

endmodule

FILE: design/sorted_list_merger.sv
// sorted_list_merger: top level, two list RAMs, merge sequencer and output register.
// Depends on slm_pkg, slm_list_ram and slm_merge_seq.
//
// Usage: send elements on the elem channel (elem_valid / elem_stall), each tagged
// with from_second for its list. Elements are transferred one per cycle while the
// block is loading; an element for a full list is dropped. The element with
// load_done set is stored, then starts the merge, and elem_stall stays high until
// the last result has been handed to the output register.
// Results leave on the res channel (res_valid / res_stall) in ascending key order,
// second list first on equal keys, with to_second, equals_next and last_out.
// Each result passes through a RAM read state (S_READ) and then a compare state
// (S_PICK) on the shared comparator, one result at a time.
// A stalled receiver holds the output register; the sequencer waits with its
// pending result until the register frees up. A load with no elements gives no
// results and keeps the block loading.
// Reset clears the counters and the sequencer; list contents are not cleared.
module sorted_list_merger import slm_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     elem_valid,
    output logic     elem_stall,
    input  key_t     elem_key,
    input  payload_t elem_payload,
    input  logic     from_second,
    input  logic     load_done,
    output logic     res_valid,
    input  logic     res_stall,
    output key_t     out_key,
    output payload_t out_payload,
    output logic     to_second,
    output logic     equals_next,
    output logic     last_out
);

    store_wr_t   wr;
    addr_t       raddr_first, raddr_second;
    entry_t      rd_first, rd_second;
    emit_req_t   emit;
    seq_status_t status;
    logic        emit_ready;

    logic        res_valid_reg;
    emit_req_t   res_reg;

    slm_list_ram #(
        .DEPTH     (LIST_DEPTH),
        .WIDTH     (ENTRY_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_first_ram (
        .clk   (clk),
        .we    (wr.we_first),
        .waddr (wr.addr_first),
        .wdata (wr.data),
        .raddr (raddr_first),
        .rdata (rd_first)
    );

    slm_list_ram #(
        .DEPTH     (LIST_DEPTH),
        .WIDTH     (ENTRY_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_second_ram (
        .clk   (clk),
        .we    (wr.we_second),
        .waddr (wr.addr_second),
        .wdata (wr.data),
        .raddr (raddr_second),
        .rdata (rd_second)
    );

    slm_merge_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .elem_valid   (elem_valid),
        .elem_key     (elem_key),
        .elem_payload (elem_payload),
        .from_second  (from_second),
        .load_done    (load_done),
        .rd_first     (rd_first),
        .rd_second    (rd_second),
        .emit_ready   (emit_ready),
        .wr           (wr),
        .raddr_first  (raddr_first),
        .raddr_second (raddr_second),
        .emit         (emit),
        .status       (status)
    );

    assign elem_stall = status.busy;
    assign emit_ready = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (emit.valid && emit_ready)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid && emit_ready)
        begin
            res_reg <= emit;
        end
    end

    assign res_valid   = res_valid_reg;
    assign out_key     = res_reg.elem.key;
    assign out_payload = res_reg.elem.payload;
    assign to_second   = res_reg.to_second;
    assign equals_next = res_reg.equals_next;
    assign last_out    = res_reg.last;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (status.first_count <= CNT_BITS'(LIST_DEPTH))
        && (status.second_count <= CNT_BITS'(LIST_DEPTH)))
        else $error("list count beyond depth");

    a_last_not_equal: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && last_out |-> !equals_next)
        else $error("final result flags equal next");

    a_done_has_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(status.busy) |-> res_valid && last_out)
        else $error("merge ended without final result in output register");

    a_no_emit_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall && !status.busy |=> $stable(out_key))
        else $error("output register changed while idle and stalled");
`endif

endmodule

FILE: tb/sv/sorted_list_merger_chk.sv
`timescale 1ns / 1ps
// sorted_list_merger_chk: watches the element and result channels of the merger, rebuilds
// both lists, predicts each merged result and compares it field by field. Depends on slm_pkg.
module sorted_list_merger_chk import slm_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     elem_valid,
    input  logic     elem_stall,
    input  key_t     elem_key,
    input  payload_t elem_payload,
    input  logic     from_second,
    input  logic     load_done,
    input  logic     res_valid,
    input  logic     res_stall,
    input  key_t     out_key,
    input  payload_t out_payload,
    input  logic     to_second,
    input  logic     equals_next,
    input  logic     last_out,
    output int       errors,
    output int       pending
);

    typedef struct packed {
        key_t     key;
        payload_t payload;
        logic     to_second;
        logic     equals_next;
        logic     last;
    } merged_t;

    key_t     first_key  [LIST_DEPTH];
    payload_t first_pay  [LIST_DEPTH];
    key_t     second_key [LIST_DEPTH];
    payload_t second_pay [LIST_DEPTH];
    int       n_first;
    int       n_second;
    merged_t  merged_q [$];
    merged_t  batch [2*LIST_DEPTH];

    always @(posedge clk or negedge rst_n)
    begin : watch
        merged_t  want;
        int       i1;
        int       i2;
        int       total;
        key_t     pick_key;
        payload_t pick_pay;
        if (!rst_n)
        begin
            n_first = 0;
            n_second = 0;
            merged_q.delete();
            errors = 0;
            pending <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (merged_q.size() == 0)
                begin
                    errors = errors + 1;
                    $display("%0t: result with none expected, got key %h payload %h",
                             $time, out_key, out_payload);
                end
                else
                begin
                    want = merged_q.pop_front();
                    if (out_key !== want.key)
                    begin
                        errors = errors + 1;
                        $display("%0t: out_key expected %h, got %h", $time, want.key, out_key);
                    end
                    if (out_payload !== want.payload)
                    begin
                        errors = errors + 1;
                        $display("%0t: out_payload expected %h, got %h",
                                 $time, want.payload, out_payload);
                    end
                    if (to_second !== want.to_second)
                    begin
                        errors = errors + 1;
                        $display("%0t: to_second expected %b, got %b",
                                 $time, want.to_second, to_second);
                    end
                    if (equals_next !== want.equals_next)
                    begin
                        errors = errors + 1;
                        $display("%0t: equals_next expected %b, got %b",
                                 $time, want.equals_next, equals_next);
                    end
                    if (last_out !== want.last)
                    begin
                        errors = errors + 1;
                        $display("%0t: last_out expected %b, got %b", $time, want.last, last_out);
                    end
                end
            end

            if (elem_valid && !elem_stall)
            begin
                // drop an element for a full list
                if (from_second)
                begin
                    if (n_second < LIST_DEPTH)
                    begin
                        second_key[n_second] = elem_key;
                        second_pay[n_second] = elem_payload;
                        n_second = n_second + 1;
                    end
                end
                else if (n_first < LIST_DEPTH)
                begin
                    first_key[n_first] = elem_key;
                    first_pay[n_first] = elem_payload;
                    n_first = n_first + 1;
                end

                if (load_done)
                begin
                    total = n_first + n_second;
                    i1 = 0;
                    i2 = 0;
                    for (int k = 0; k < total; k++)
                    begin
                        if (i1 < n_first && (i2 >= n_second || first_key[i1] < second_key[i2]))
                        begin
                            pick_key = first_key[i1];
                            pick_pay = first_pay[i1];
                            i1 = i1 + 1;
                        end
                        else
                        begin
                            pick_key = second_key[i2];
                            pick_pay = second_pay[i2];
                            i2 = i2 + 1;
                        end
                        batch[k].key = pick_key;
                        batch[k].payload = pick_pay;
                        batch[k].to_second = (k >= n_first);
                        batch[k].equals_next = 1'b0;
                        batch[k].last = (k == total - 1);
                        if (k > 0 && batch[k-1].key == pick_key)
                            batch[k-1].equals_next = 1'b1;
                    end
                    for (int k = 0; k < total; k++)
                        merged_q.push_back(batch[k]);
                    n_first = 0;
                    n_second = 0;
                end
            end
            pending <= merged_q.size();
        end
    end

endmodule

FILE: tb/sv/sorted_list_merger_tb.sv
`timescale 1ns / 1ps
// sorted_list_merger_tb: drives sorted, unsorted and overflowing loads into the merger with
// random gaps and stalls, and gives the verdict. Depends on slm_pkg, the merger and its checker.
module sorted_list_merger_tb;
    import slm_pkg::*;

    localparam int IDLE_LIMIT   = 3000;
    localparam int TARGET_ITEMS = 470;
    localparam int MAX_LOAD     = 48;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     elem_valid = 1'b0;
    logic     elem_stall;
    key_t     elem_key = '0;
    payload_t elem_payload = '0;
    logic     from_second = 1'b0;
    logic     load_done = 1'b0;
    logic     res_valid;
    logic     res_stall = 1'b0;
    key_t     out_key;
    payload_t out_payload;
    logic     to_second;
    logic     equals_next;
    logic     last_out;

    int errors;
    int pending;
    int items_sent = 0;
    int idle_cycles = 0;
    int hold_cnt = 0;
    bit valid_up = 1'b0;
    bit sender_quiet = 1'b0;
    bit recv_quiet = 1'b0;

    sorted_list_merger DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .elem_valid   (elem_valid),
        .elem_stall   (elem_stall),
        .elem_key     (elem_key),
        .elem_payload (elem_payload),
        .from_second  (from_second),
        .load_done    (load_done),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .out_key      (out_key),
        .out_payload  (out_payload),
        .to_second    (to_second),
        .equals_next  (equals_next),
        .last_out     (last_out)
    );

    sorted_list_merger_chk u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .elem_valid   (elem_valid),
        .elem_stall   (elem_stall),
        .elem_key     (elem_key),
        .elem_payload (elem_payload),
        .from_second  (from_second),
        .load_done    (load_done),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .out_key      (out_key),
        .out_payload  (out_payload),
        .to_second    (to_second),
        .equals_next  (equals_next),
        .last_out     (last_out),
        .errors       (errors),
        .pending      (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver: hold off a random number of cycles after each transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if ($urandom_range(0, 29) == 0)
                    recv_quiet = !recv_quiet;
                hold_cnt = recv_quiet ? 0 : $urandom_range(0, 13);
            end
            else if (hold_cnt > 0)
                hold_cnt = hold_cnt - 1;
            res_stall <= (hold_cnt > 0);
        end
    end

    always @(posedge clk)
    begin
        if ((elem_valid && !elem_stall) || (res_valid && !res_stall))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[sorted_list_merger] ERROR");
            $finish;
        end
    end

    task automatic drop_valid();
        if (valid_up)
        begin
            elem_valid <= 1'b0;
            valid_up = 1'b0;
        end
    endtask

    task automatic send_elem(input key_t key, input payload_t pay, input bit sec, input bit done);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            drop_valid();
            repeat (gap) @(posedge clk);
        end
        elem_key     <= key;
        elem_payload <= pay;
        from_second  <= sec;
        load_done    <= done;
        elem_valid   <= 1'b1;
        valid_up = 1'b1;
        @(posedge clk);
        while (elem_stall)
            @(posedge clk);
        items_sent = items_sent + 1;
    endtask

    task automatic wait_drain();
        drop_valid();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // spread: 0 narrow (many equal keys), 1 mid, 2 full range, 3 near top, 4 unsorted
    task automatic send_load(input int n1, input int n2, input int spread);
        key_t keys [2][MAX_LOAD];
        key_t tmp;
        int   cnt [2];
        int   idx [2];
        int   total;
        int   j;
        int   l;
        cnt[0] = n1;
        cnt[1] = n2;
        for (int s = 0; s < 2; s++)
        begin
            for (int i = 0; i < cnt[s]; i++)
            begin
                case (spread)
                    0: keys[s][i] = $urandom_range(0, 7);
                    1: keys[s][i] = $urandom_range(0, 1000);
                    3: keys[s][i] = 32'hFFFF_FFFF - $urandom_range(0, 8);
                    default: keys[s][i] = $urandom;
                endcase
            end
            if (spread != 4)
            begin
                for (int i = 1; i < cnt[s]; i++)
                begin
                    tmp = keys[s][i];
                    j = i - 1;
                    while (j >= 0 && keys[s][j] > tmp)
                    begin
                        keys[s][j+1] = keys[s][j];
                        j = j - 1;
                    end
                    keys[s][j+1] = tmp;
                end
            end
        end
        idx[0] = 0;
        idx[1] = 0;
        total = n1 + n2;
        for (int i = 0; i < total; i++)
        begin
            if (idx[0] == cnt[0])
                l = 1;
            else if (idx[1] == cnt[1])
                l = 0;
            else
                l = $urandom_range(0, 1);
            send_elem(keys[l][idx[l]], $urandom, l[0], i == total - 1);
            idx[l] = idx[l] + 1;
        end
    endtask

    initial
    begin
        int n1;
        int n2;
        int pick;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_elem(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1);
        send_elem(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_elem(32'd5, 32'h1111_1111, 1'b0, 1'b0);
        send_elem(32'd5, 32'h2222_2222, 1'b1, 1'b0);
        send_elem(32'd7, 32'h3333_3333, 1'b0, 1'b1);
        send_elem(32'd9, 32'hA5A5_A5A5, 1'b0, 1'b0);
        send_elem(32'd1, 32'h5A5A_5A5A, 1'b0, 1'b0);
        send_elem(32'd4, 32'h0F0F_0F0F, 1'b1, 1'b1);
        send_elem(32'd3, 32'h0000_0001, 1'b1, 1'b0);
        send_elem(32'd3, 32'h0000_0002, 1'b1, 1'b0);
        send_elem(32'd3, 32'h0000_0003, 1'b0, 1'b0);
        send_elem(32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
        send_elem(32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1);
        send_elem(32'd10, 32'hDEAD_0001, 1'b1, 1'b0);
        send_elem(32'd20, 32'hDEAD_0002, 1'b1, 1'b1);
        wait_drain();

        while (items_sent < TARGET_ITEMS)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
            begin
                n1 = $urandom_range(33, 40);
                n2 = $urandom_range(0, 4);
            end
            else if (pick == 1)
            begin
                n1 = $urandom_range(0, 4);
                n2 = $urandom_range(33, 40);
            end
            else if (pick == 2)
            begin
                n1 = LIST_DEPTH;
                n2 = LIST_DEPTH;
            end
            else
            begin
                n1 = $urandom_range(0, 8);
                n2 = $urandom_range(0, 8);
                if (n1 + n2 == 0)
                    n1 = 1;
            end
            send_load(n1, n2, ($urandom_range(0, 9) == 0) ? 4 : $urandom_range(0, 3));
            if ($urandom_range(0, 5) == 0)
                wait_drain();
            if ($urandom_range(0, 4) == 0)
                sender_quiet = !sender_quiet;
        end

        wait_drain();
        repeat (12) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("[sorted_list_merger] OK");
        else
            $display("[sorted_list_merger] ERROR");
        $finish;
    end

endmodule
